@@ rtl/cbpf_pkg.sv @@
// shared types and constants of the closed bezier path flattener
package cbpf_pkg;

    localparam int COORD_W       = 32;
    localparam int WEIGHT_W      = 17;
    localparam int PROD_W        = COORD_W + WEIGHT_W + 1;
    localparam int SUM_W         = PROD_W + 2;
    localparam int FRAC_W        = 16;
    localparam int STEPS_DEFAULT = 12;
    localparam int STEPS_MAX     = 32;
    localparam int QUEUE_DEFAULT = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // one unit of back-end work: a single point or a full cubic segment
    typedef struct packed {
        logic   is_point;
        logic   mark_last;
        point_t p0;
        point_t p1;
        point_t p2;
        point_t p3;
    } job_t;

endpackage

@@ rtl/cbpf_queue.sv @@
// small register queue carrying jobs from the front end to the evaluator
module cbpf_queue #(
    parameter int DEPTH = cbpf_pkg::QUEUE_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cbpf_pkg::job_t  in_job,
    output logic            out_valid,
    input  logic            out_ready,
    output cbpf_pkg::job_t  out_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbpf_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers apart while empty");

endmodule

@@ rtl/cbpf_front.sv @@
// front end: takes path nodes, tracks the open path and queues segment jobs
module cbpf_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cbpf_pkg::coord_t       s_anchor_x,
    input  cbpf_pkg::coord_t       s_anchor_y,
    input  cbpf_pkg::coord_t       s_leave_x,
    input  cbpf_pkg::coord_t       s_leave_y,
    input  cbpf_pkg::coord_t       s_enter_x,
    input  cbpf_pkg::coord_t       s_enter_y,
    input  logic                   s_last_node,
    output logic                   job_valid,
    input  logic                   job_ready,
    output cbpf_pkg::job_t         job
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_FIRST = 3'b010,
        F_CLOSE = 3'b100
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic              open_reg, open_next;
    cbpf_pkg::point_t  start_reg;
    cbpf_pkg::point_t  held_anchor_reg, held_leave_reg, held_enter_reg;
    cbpf_pkg::point_t  node_anchor_reg, node_leave_reg, node_enter_reg;
    logic              node_last_reg;
    logic              take, push;

    assign s_ready = (state_reg == F_IDLE);
    assign take    = s_valid && s_ready;
    assign push    = job_valid && job_ready;

    always_comb begin
        job_valid     = 1'b0;
        job.is_point  = 1'b0;
        job.mark_last = 1'b0;
        job.p0        = held_anchor_reg;
        job.p1        = held_leave_reg;
        job.p2        = held_enter_reg;
        job.p3        = node_anchor_reg;
        case (state_reg)
            F_IDLE: begin
                job_valid = 1'b0;
            end
            F_FIRST: begin
                job_valid = 1'b1;
                if (!open_reg) begin
                    // opening node emits its own anchor
                    job.is_point = 1'b1;
                    job.p0       = node_anchor_reg;
                end
            end
            F_CLOSE: begin
                // held node already holds this node: close back to the start
                job_valid     = 1'b1;
                job.mark_last = 1'b1;
                job.p3        = start_reg;
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        open_next  = open_reg;
        case (state_reg)
            F_IDLE: begin
                if (take) begin
                    state_next = F_FIRST;
                end
            end
            F_FIRST: begin
                if (push) begin
                    open_next  = 1'b1;
                    state_next = node_last_reg ? F_CLOSE : F_IDLE;
                end
            end
            F_CLOSE: begin
                if (push) begin
                    open_next  = 1'b0;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            open_reg        <= 1'b0;
            start_reg       <= '0;
            held_anchor_reg <= '0;
            held_leave_reg  <= '0;
            held_enter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            if (state_reg == F_FIRST && push) begin
                held_anchor_reg <= node_anchor_reg;
                held_leave_reg  <= node_leave_reg;
                held_enter_reg  <= node_enter_reg;
                if (!open_reg) begin
                    start_reg <= node_anchor_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            node_anchor_reg <= '{x: s_anchor_x, y: s_anchor_y};
            node_leave_reg  <= '{x: s_leave_x, y: s_leave_y};
            node_enter_reg  <= '{x: s_enter_x, y: s_enter_y};
            node_last_reg   <= s_last_node;
        end
    end

    a_close_needs_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_CLOSE) |-> (open_reg && node_last_reg))
        else $error("closing segment without an open last node");

    a_point_only_opening: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && job.is_point) |-> (!open_reg && state_reg == F_FIRST))
        else $error("anchor point queued inside an open path");

endmodule

@@ rtl/cbpf_eval.sv @@
// back end: steps each job through t = k/n and blends the cubic per point
module cbpf_eval #(
    parameter int CURVE_STEPS = cbpf_pkg::STEPS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  cbpf_pkg::job_t         job,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cbpf_pkg::coord_t       m_point_x,
    output cbpf_pkg::coord_t       m_point_y,
    output logic                   m_last_point
);

    localparam int N = (CURVE_STEPS < 1) ? 1 :
                       (CURVE_STEPS > cbpf_pkg::STEPS_MAX) ? cbpf_pkg::STEPS_MAX :
                       CURVE_STEPS;
    localparam int STEP_W = $clog2(N + 1);
    localparam int WW     = cbpf_pkg::WEIGHT_W;
    localparam int PW     = cbpf_pkg::PROD_W;
    localparam int SW     = cbpf_pkg::SUM_W;
    localparam int CW     = cbpf_pkg::COORD_W;
    localparam int RW     = SW - cbpf_pkg::FRAC_W;

    // bernstein weights in q1.16, row k = 0 is the identity used for anchors
    logic [WW-1:0] w_tab [N+1][4];

    for (genvar k = 0; k <= N; k++) begin : g_weight
        localparam logic [63:0] U = 64'(N - k);
        localparam logic [63:0] T = 64'(k);
        localparam logic [63:0] D = 64'(N) * 64'(N) * 64'(N);
        localparam logic [63:0] W0 = (U * U * U * 64'd131072 + D) / (64'd2 * D);
        localparam logic [63:0] W1 = (64'd3 * U * U * T * 64'd131072 + D) / (64'd2 * D);
        localparam logic [63:0] W2 = (64'd3 * U * T * T * 64'd131072 + D) / (64'd2 * D);
        localparam logic [63:0] W3 = (T * T * T * 64'd131072 + D) / (64'd2 * D);
        assign w_tab[k][0] = W0[WW-1:0];
        assign w_tab[k][1] = W1[WW-1:0];
        assign w_tab[k][2] = W2[WW-1:0];
        assign w_tab[k][3] = W3[WW-1:0];
    end

    logic                 en, issue, last_step;
    logic [STEP_W-1:0]    cnt_reg, cnt_next, step;
    logic                 s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic                 s1_last_reg, s2_last_reg, out_last_reg;
    logic signed [PW-1:0] prod_x_reg [4];
    logic signed [PW-1:0] prod_y_reg [4];
    logic signed [SW-1:0] sum_x_reg, sum_y_reg;
    cbpf_pkg::coord_t     out_x_reg, out_y_reg;
    cbpf_pkg::coord_t     cx [4];
    cbpf_pkg::coord_t     cy [4];

    function automatic cbpf_pkg::coord_t round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] biased;
        logic signed [RW-1:0] r;
        biased = s + SW'(32768);
        r      = biased[SW-1:cbpf_pkg::FRAC_W];
        if (r > RW'(64'sd2147483647)) begin
            return {1'b0, {(CW-1){1'b1}}};
        end else if (r < -RW'(64'sd2147483648)) begin
            return {1'b1, {(CW-1){1'b0}}};
        end
        return r[CW-1:0];
    endfunction

    // whole pipeline holds while the output register waits
    assign en        = !out_valid_reg || m_ready;
    assign issue     = en && job_valid;
    assign last_step = job.is_point || (cnt_reg == STEP_W'(N - 1));
    assign step      = job.is_point ? '0 : cnt_reg + 1'b1;
    assign job_ready = issue && last_step;

    assign cx[0] = job.p0.x;
    assign cx[1] = job.p1.x;
    assign cx[2] = job.p2.x;
    assign cx[3] = job.p3.x;
    assign cy[0] = job.p0.y;
    assign cy[1] = job.p1.y;
    assign cy[2] = job.p2.y;
    assign cy[3] = job.p3.y;

    always_comb begin
        cnt_next = cnt_reg;
        if (issue) begin
            cnt_next = last_step ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (en) begin
                s1_valid_reg  <= job_valid;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                prod_x_reg[i] <= PW'($signed({1'b0, w_tab[step][i]}) * cx[i]);
                prod_y_reg[i] <= PW'($signed({1'b0, w_tab[step][i]}) * cy[i]);
            end
            s1_last_reg  <= job.mark_last && last_step;
            sum_x_reg    <= SW'(prod_x_reg[0]) + SW'(prod_x_reg[1])
                          + SW'(prod_x_reg[2]) + SW'(prod_x_reg[3]);
            sum_y_reg    <= SW'(prod_y_reg[0]) + SW'(prod_y_reg[1])
                          + SW'(prod_y_reg[2]) + SW'(prod_y_reg[3]);
            s2_last_reg  <= s1_last_reg;
            out_x_reg    <= round_sat(sum_x_reg);
            out_y_reg    <= round_sat(sum_y_reg);
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_point_x    = out_x_reg;
    assign m_point_y    = out_y_reg;
    assign m_last_point = out_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= STEP_W'(N - 1))
        else $error("step counter past the last step");

    a_cnt_in_curve: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (job_valid && !job.is_point))
        else $error("segment left the queue head before its last step");

endmodule

@@ rtl/closed_bezier_path_flattener.sv @@
// top level of the closed bezier path flattener: front end, job queue, evaluator
// Nodes of a closed path go in one per request; points come out one per request.
// The first node of a path gives its anchor, each later node the CURVE_STEPS
// points of the cubic from the previous node, and the node marked last adds the
// closing cubic back to the first anchor, its final point flagged in
// m_last_point. The evaluator makes one point per cycle while the output is not
// stalled; each point passes through the product, sum and rounded output
// registers. The front end takes no new node until the jobs of the last one
// are queued, so the evaluator sets the sustained rate, while the queue of
// QUEUE_DEPTH jobs lets new nodes enter while earlier segments are still
// being drawn.
module closed_bezier_path_flattener #(
    parameter int CURVE_STEPS = cbpf_pkg::STEPS_DEFAULT,
    parameter int QUEUE_DEPTH = cbpf_pkg::QUEUE_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cbpf_pkg::coord_t  s_anchor_x,
    input  cbpf_pkg::coord_t  s_anchor_y,
    input  cbpf_pkg::coord_t  s_leave_x,
    input  cbpf_pkg::coord_t  s_leave_y,
    input  cbpf_pkg::coord_t  s_enter_x,
    input  cbpf_pkg::coord_t  s_enter_y,
    input  logic              s_last_node,
    output logic              m_valid,
    input  logic              m_ready,
    output cbpf_pkg::coord_t  m_point_x,
    output cbpf_pkg::coord_t  m_point_y,
    output logic              m_last_point
);

    logic            fq_valid, fq_ready;
    cbpf_pkg::job_t  fq_job;
    logic            qe_valid, qe_ready;
    cbpf_pkg::job_t  qe_job;

    cbpf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_anchor_x  (s_anchor_x),
        .s_anchor_y  (s_anchor_y),
        .s_leave_x   (s_leave_x),
        .s_leave_y   (s_leave_y),
        .s_enter_x   (s_enter_x),
        .s_enter_y   (s_enter_y),
        .s_last_node (s_last_node),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job         (fq_job)
    );

    cbpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_job   (qe_job)
    );

    cbpf_eval #(
        .CURVE_STEPS (CURVE_STEPS)
    ) u_eval (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (qe_valid),
        .job_ready    (qe_ready),
        .job          (qe_job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_last_point (m_last_point)
    );

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the closed bezier path flattener
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef cbpf_pkg::coord_t coord_t;
    typedef cbpf_pkg::point_t point_t;

    localparam int CURVE_STEPS    = 12;
    localparam int STEPS_N        = (CURVE_STEPS < 1) ? 1 :
                                    (CURVE_STEPS > cbpf_pkg::STEPS_MAX) ?
                                    cbpf_pkg::STEPS_MAX : CURVE_STEPS;
    localparam int RANDOM_NODES   = 450;
    localparam int MAX_WAIT       = 18;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam coord_t C_MAX  = 32'sh7fff_ffff;
    localparam coord_t C_MIN  = 32'sh8000_0000;
    localparam coord_t C_ZERO = 32'sh0000_0000;
    localparam coord_t C_ONE  = 32'sh0000_0001;
    localparam coord_t C_NEG1 = 32'shffff_ffff;
    localparam coord_t C_A5   = 32'sh5555_5555;
    localparam coord_t C_5A   = 32'shaaaa_aaaa;

    typedef struct {
        point_t anchor;
        point_t leave;
        point_t enter;
        logic   last;
    } path_node_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } flat_point_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_anchor_x = '0;
    coord_t s_anchor_y = '0;
    coord_t s_leave_x = '0;
    coord_t s_leave_y = '0;
    coord_t s_enter_x = '0;
    coord_t s_enter_y = '0;
    logic   s_last_node = 1'b0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_point_x;
    coord_t m_point_y;
    logic   m_last_point;

    path_node_t  pending_nodes[$];
    flat_point_t expected_points[$];
    path_node_t  next_node;
    flat_point_t want;

    // predictor state
    point_t path_start = '0;
    point_t prev_anchor = '0;
    point_t prev_leave = '0;
    point_t prev_enter = '0;
    bit     path_open = 1'b0;

    bit node_taken = 1'b0;
    bit point_taken = 1'b0;
    bit point_expected = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int node_total;
    int path_len;

    closed_bezier_path_flattener #(
        .CURVE_STEPS(CURVE_STEPS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_anchor_x  (s_anchor_x),
        .s_anchor_y  (s_anchor_y),
        .s_leave_x   (s_leave_x),
        .s_leave_y   (s_leave_y),
        .s_enter_x   (s_enter_x),
        .s_enter_y   (s_enter_y),
        .s_last_node (s_last_node),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_point_x   (m_point_x),
        .m_point_y   (m_point_y),
        .m_last_point(m_last_point)
    );

    always #5 aclk = ~aclk;

    function automatic void add_node(path_node_t nd);
        pending_nodes.insert(pending_nodes.size(), nd);
    endfunction

    function automatic void add_point(flat_point_t pt);
        expected_points.insert(expected_points.size(), pt);
    endfunction

    // one coordinate of the cubic at t = k/n, Q16.16 rounded half up and saturated
    function automatic coord_t bezier_coord(int k, coord_t c0, coord_t c1, coord_t c2,
                                            coord_t c3);
        longint u;
        longint t;
        longint d;
        longint w0;
        longint w1;
        longint w2;
        longint w3;
        longint acc;
        longint r;
        u   = STEPS_N - k;
        t   = k;
        d   = longint'(STEPS_N) * STEPS_N * STEPS_N;
        w0  = (u * u * u * 131072 + d) / (2 * d);
        w1  = (3 * u * u * t * 131072 + d) / (2 * d);
        w2  = (3 * u * t * t * 131072 + d) / (2 * d);
        w3  = (t * t * t * 131072 + d) / (2 * d);
        acc = w0 * longint'(c0) + w1 * longint'(c1) + w2 * longint'(c2) + w3 * longint'(c3);
        r   = (acc + 32768) >>> 16;
        if (r > longint'(C_MAX))
            r = longint'(C_MAX);
        if (r < longint'(C_MIN))
            r = longint'(C_MIN);
        return coord_t'(r);
    endfunction

    task automatic push_cubic(point_t p0, point_t p1, point_t p2, point_t p3, bit mark_last);
        flat_point_t pt;
        for (int k = 1; k <= STEPS_N; k++) begin
            pt.x    = bezier_coord(k, p0.x, p1.x, p2.x, p3.x);
            pt.y    = bezier_coord(k, p0.y, p1.y, p2.y, p3.y);
            pt.last = mark_last && (k == STEPS_N);
            add_point(pt);
        end
    endtask

    task automatic flatten_node(point_t anchor, point_t leave, point_t enter, logic last);
        flat_point_t pt;
        if (!path_open) begin
            pt.x    = anchor.x;
            pt.y    = anchor.y;
            pt.last = 1'b0;
            add_point(pt);
            path_start = anchor;
            path_open  = 1'b1;
        end else begin
            push_cubic(prev_anchor, prev_leave, prev_enter, anchor, 1'b0);
        end
        prev_anchor = anchor;
        prev_leave  = leave;
        prev_enter  = enter;
        if (last) begin
            push_cubic(anchor, leave, enter, path_start, 1'b1);
            path_open = 1'b0;
        end
    endtask

    function automatic path_node_t make_node(coord_t ax, coord_t ay, coord_t lx, coord_t ly,
                                             coord_t ex, coord_t ey, logic last);
        path_node_t nd;
        nd.anchor = {ax, ay};
        nd.leave  = {lx, ly};
        nd.enter  = {ex, ey};
        nd.last   = last;
        return nd;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return C_ZERO;
            3, 4, 5: return coord_t'($urandom());
            default: return coord_t'(int'($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || node_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_nodes.size() > 0) begin
                next_node = pending_nodes.pop_front();
                s_anchor_x  <= next_node.anchor.x;
                s_anchor_y  <= next_node.anchor.y;
                s_leave_x   <= next_node.leave.x;
                s_leave_y   <= next_node.leave.y;
                s_enter_x   <= next_node.enter.x;
                s_enter_y   <= next_node.enter.y;
                s_last_node <= next_node.last;
                s_valid     <= 1'b1;
                send_gap = draw_wait(send_calm);
                if ($urandom_range(0, 29) == 0)
                    send_calm = !send_calm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (point_taken) begin
                stall_left = draw_wait(recv_calm);
                if ($urandom_range(0, 29) == 0)
                    recv_calm = !recv_calm;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: predicts on each accepted request, checks each accepted point
    always @(posedge aclk) begin
        node_taken  = aresetn && s_valid && s_ready;
        point_taken = aresetn && m_valid && m_ready;
        if (node_taken)
            flatten_node({s_anchor_x, s_anchor_y}, {s_leave_x, s_leave_y},
                         {s_enter_x, s_enter_y}, s_last_node);
        // a stream of unlooked-for points does not count as progress
        point_expected = point_taken && (expected_points.size() > 0);
        if (point_taken) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point: x %0d y %0d last %0b",
                       m_point_x, m_point_y, m_last_point);
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                if (m_point_x !== want.x) begin
                    $error("point_x: expected %0d, got %0d", want.x, m_point_x);
                    mismatches++;
                end
                if (m_point_y !== want.y) begin
                    $error("point_y: expected %0d, got %0d", want.y, m_point_y);
                    mismatches++;
                end
                if (m_last_point !== want.last) begin
                    $error("last_point: expected %0b, got %0b", want.last, m_last_point);
                    mismatches++;
                end
            end
        end
        if (node_taken || point_expected || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // single-node paths: close back onto their own anchor
        add_node(make_node(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1));
        add_node(make_node(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
        add_node(make_node(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1));
        add_node(make_node(C_A5, C_5A, C_5A, C_A5, C_NEG1, C_ONE, 1'b1));
        // three-node path swinging between the extremes
        add_node(make_node(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0));
        add_node(make_node(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0));
        add_node(make_node(C_A5, C_5A, C_ZERO, C_NEG1, C_ONE, C_ZERO, 1'b1));
        // two-node path near zero, exercising rounding of tiny values
        add_node(make_node(C_ONE, C_NEG1, C_NEG1, C_ONE, C_ONE, C_ONE, 1'b0));
        add_node(make_node(C_NEG1, C_ONE, C_ZERO, C_ZERO, C_NEG1, C_NEG1, 1'b1));
        // overshooting control points at full scale
        add_node(make_node(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
        add_node(make_node(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0));
        add_node(make_node(C_5A, C_A5, C_A5, C_5A, C_ZERO, C_MAX, 1'b0));
        add_node(make_node(C_ZERO, C_MIN, C_MAX, C_ZERO, C_MIN, C_MAX, 1'b1));

        node_total = 0;
        while (node_total < RANDOM_NODES) begin
            path_len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 14)
                                                    : $urandom_range(1, 6);
            for (int i = 0; i < path_len; i++)
                add_node(make_node(rand_coord(), rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), rand_coord(),
                                   i == path_len - 1));
            node_total += path_len;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_nodes.size() > 0 || s_valid)
            @(posedge aclk);
        while (expected_points.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_points.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
